[src/pns_pkg.sv]
// Shared types, constants and helpers for the peak normalizer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pns_pkg;

  // Sample store geometry.
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Gain and peak widths.
  localparam int GAIN_W = 30;
  localparam int PEAK_W = 15;
  localparam int REM_W  = PEAK_W + 1;
  localparam int STEP_W = $clog2(GAIN_W);

  // Numerators of the gain division: 128*127 and 32768*32767.
  localparam logic [GAIN_W-1:0] NUM_8  = GAIN_W'(128 * 127);
  localparam logic [GAIN_W-1:0] NUM_16 = GAIN_W'(32768 * 32767);

  // Sample width codes.
  localparam logic MODE_8  = 1'b0;
  localparam logic MODE_16 = 1'b1;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One input item.
  typedef struct packed {
    logic                cmd;
    logic signed [15:0]  sample_in;
    logic                last_in;
    logic [ADDR_W-1:0]   read_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [15:0]  sample_out;
    logic                index_error;
  } out_item_t;

  // One classified operation, as queued from the front to the back.
  typedef struct packed {
    logic                is_read;
    logic                wr_en;
    logic [ADDR_W-1:0]   addr;
    logic [15:0]         data;
    logic                div_go;
    logic [PEAK_W-1:0]   divisor;
    logic                rd_err;
    logic                rd_scale;
  } op_t;

  // Request from the back to the gain divider.
  typedef struct packed {
    logic                go;
    logic                mode;
    logic [PEAK_W-1:0]   divisor;
  } div_req_t;

  // Interpret a raw 16-bit word as a sample of the given width.
  function automatic logic signed [15:0] sample_ext(input logic [15:0] raw,
                                                    input logic mode);
    logic signed [15:0] val;
    if (mode == MODE_8) begin
      val = {{8{raw[7]}}, raw[7:0]};
    end else begin
      val = raw;
    end
    return val;
  endfunction

endpackage

[src/pns_front.sv]
// Front end: accepts commands, tracks set count and peak, and classifies
// each command into a queued operation. Depends on pns_pkg.
`timescale 1ns / 1ps

module pns_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  pns_pkg::in_item_t     in_data,
  input  logic                  mode,
  input  logic                  q_full,
  output logic                  push,
  output pns_pkg::op_t          push_op
);

  logic [pns_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [pns_pkg::PEAK_W-1:0]  peak_r, peak_nxt;
  logic                        closed_r, closed_nxt;

  logic [pns_pkg::COUNT_W-1:0] base_count;
  logic [pns_pkg::PEAK_W-1:0]  base_peak;
  logic                        store_ok;
  logic signed [15:0]          samp;
  logic                        bigger;
  logic [pns_pkg::PEAK_W-1:0]  load_peak;

  assign push = start && !q_full;

  // A load after a closed set opens a new set from empty.
  assign base_count = closed_r ? '0 : count_r;
  assign base_peak  = closed_r ? '0 : peak_r;
  assign store_ok   = (base_count != pns_pkg::COUNT_W'(pns_pkg::STORE_DEPTH));
  assign samp       = pns_pkg::sample_ext(in_data.sample_in, mode);
  assign bigger     = !samp[15] && (samp[pns_pkg::PEAK_W-1:0] > base_peak);
  assign load_peak  = (store_ok && bigger) ? samp[pns_pkg::PEAK_W-1:0] : base_peak;

  // Classify the command and compute the next tracking state.
  always_comb begin
    push_op          = '0;
    push_op.addr     = in_data.read_index;
    count_nxt        = count_r;
    peak_nxt         = peak_r;
    closed_nxt       = closed_r;
    if (in_data.cmd == pns_pkg::CMD_LOAD) begin
      push_op.is_read = 1'b0;
      push_op.wr_en   = store_ok;
      push_op.addr    = base_count[pns_pkg::ADDR_W-1:0];
      push_op.data    = in_data.sample_in;
      push_op.div_go  = in_data.last_in;
      push_op.divisor = (load_peak == '0) ? pns_pkg::PEAK_W'(1) : load_peak;
      count_nxt       = store_ok ? base_count + 1'b1 : base_count;
      peak_nxt        = load_peak;
      closed_nxt      = in_data.last_in;
    end else begin
      push_op.is_read  = 1'b1;
      push_op.rd_err   = ({1'b0, in_data.read_index} >= count_r);
      push_op.rd_scale = closed_r && (peak_r != '0);
    end
  end

  // Tracking state advances on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      peak_r   <= '0;
      closed_r <= 1'b0;
    end else if (push) begin
      count_r  <= count_nxt;
      peak_r   <= peak_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

[src/pns_queue.sv]
// Short operation queue that decouples the front from the back.
// Depends on pns_pkg for the operation type and depth.
`timescale 1ns / 1ps

module pns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pns_pkg::op_t   push_op,
  input  logic           pop,
  output pns_pkg::op_t   head_op,
  output logic           empty,
  output logic           full
);

  pns_pkg::op_t               slots_r [pns_pkg::QUEUE_DEPTH];
  logic [pns_pkg::QPTR_W-1:0] wptr_r;
  logic [pns_pkg::QPTR_W-1:0] rptr_r;
  logic [pns_pkg::QCNT_W-1:0] cnt_r;

  assign head_op = slots_r[rptr_r];
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == pns_pkg::QCNT_W'(pns_pkg::QUEUE_DEPTH));

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_op;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/pns_div.sv]
// Restoring divider for the gain: one quotient bit per cycle.
// Depends on pns_pkg for widths and numerators.
`timescale 1ns / 1ps

module pns_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pns_pkg::div_req_t          req,
  output logic                       busy,
  output logic                       done,
  output logic [pns_pkg::GAIN_W-1:0] quotient
);

  logic                        busy_r;
  logic [pns_pkg::STEP_W-1:0]  step_r;
  logic [pns_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [pns_pkg::GAIN_W-1:0]  q_r, q_nxt;
  logic [pns_pkg::PEAK_W-1:0]  dsr_r;
  logic [pns_pkg::REM_W-1:0]   rem_sh;
  logic                        ge;

  assign busy     = busy_r;
  assign done     = busy_r && (step_r == pns_pkg::STEP_W'(pns_pkg::GAIN_W - 1));
  assign quotient = q_nxt;

  // One shift-and-subtract step; the numerator shifts out of the quotient.
  always_comb begin
    rem_sh  = {rem_r[pns_pkg::REM_W-2:0], q_r[pns_pkg::GAIN_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
    q_nxt   = {q_r[pns_pkg::GAIN_W-2:0], ge};
  end

  // Control: busy from a request until the last quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.go) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      busy_r <= !done;
      step_r <= step_r + 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      q_r   <= (req.mode == pns_pkg::MODE_8) ? pns_pkg::NUM_8 : pns_pkg::NUM_16;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule

[src/pns_back.sv]
// Back end: sample store, gain divider, and the scaling pipeline.
// Depends on pns_pkg and pns_div.
`timescale 1ns / 1ps

module pns_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mode,
  input  pns_pkg::op_t          head_op,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  output pns_pkg::out_item_t    out_data
);

  logic [15:0]                 store_mem [pns_pkg::STORE_DEPTH];
  pns_pkg::div_req_t           div_req;
  logic                        div_busy;
  logic                        div_done;
  logic [pns_pkg::GAIN_W-1:0]  div_q;
  logic [pns_pkg::GAIN_W-1:0]  gain_r;

  logic                        s1_valid_r;
  logic                        s1_err_r;
  logic                        s1_scale_r;
  logic [15:0]                 s1_word_r;

  logic                        s2_valid_r;
  logic                        s2_err_r;
  logic                        s2_scale_r;
  logic signed [15:0]          s2_samp_r;
  logic [30:0]                 s2_prod_r;

  logic signed [15:0]          s1_samp;
  logic signed [46:0]          s1_prod;
  logic signed [15:0]          s2_scaled;
  logic signed [15:0]          s2_result;

  logic                        out_valid_r;
  pns_pkg::out_item_t          out_data_r;

  // Operations leave the queue in order while the divider is idle.
  assign pop = !q_empty && !div_busy;

  assign div_req.go      = pop && head_op.div_go;
  assign div_req.mode    = mode;
  assign div_req.divisor = head_op.divisor;

  pns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Gain register, loaded when a division finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (div_done) begin
      gain_r <= div_q;
    end
  end

  // Sample store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pop && head_op.wr_en) begin
      store_mem[head_op.addr] <= head_op.data;
    end
    if (pop && head_op.is_read) begin
      s1_word_r <= store_mem[head_op.addr];
    end
  end

  // Stage one control follows the read issue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pop && head_op.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.is_read) begin
      s1_err_r   <= head_op.rd_err;
      s1_scale_r <= head_op.rd_scale;
    end
  end

  // Stage two: widen the stored word and multiply by the gain.
  assign s1_samp = pns_pkg::sample_ext(s1_word_r, mode);
  assign s1_prod = s1_samp * $signed({1'b0, gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_err_r   <= s1_err_r;
      s2_scale_r <= s1_scale_r;
      s2_samp_r  <= s1_samp;
      s2_prod_r  <= s1_prod[30:0];
    end
  end

  // Stage three: shift down, wrap to the sample width and pick the result.
  always_comb begin
    if (mode == pns_pkg::MODE_8) begin
      s2_scaled = {{8{s2_prod_r[14]}}, s2_prod_r[14:7]};
    end else begin
      s2_scaled = s2_prod_r[30:15];
    end
    if (s2_err_r) begin
      s2_result = '0;
    end else if (s2_scale_r) begin
      s2_result = s2_scaled;
    end else begin
      s2_result = s2_samp_r;
    end
  end

  // Output register: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_data_r.sample_out  <= s2_result;
      out_data_r.index_error <= s2_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/peak_normalize_samples.sv]
// Top level of the peak normalizer: front end, operation queue, back end
// and the sample width register. Depends on pns_pkg, pns_front, pns_queue, pns_back.
//
//   Channel   Ports                       Transfer rule
//   input     start, busy, in_data        start high and busy low at a clock edge
//   result    out_valid, out_data         out_valid high for one cycle, always taken
//   config    cfg_we, cfg_wdata           cfg_we high at a clock edge
//
// Loads and reads are taken one per cycle while busy is low; with an empty queue a
// read result passes through the queue entry, the store read, stage two and
// the output register to the result ports. A load that closes a set starts the
// gain division, which holds the back end until its last quotient bit (one quotient
// bit per cycle); busy rises when the four-entry queue fills behind it.
// Reset is synchronous and active low; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
`timescale 1ns / 1ps

module peak_normalize_samples (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  pns_pkg::in_item_t     in_data,
  output logic                  out_valid,
  output pns_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  logic          mode_r;
  logic          push;
  pns_pkg::op_t  push_op;
  pns_pkg::op_t  head_op;
  logic          q_empty;
  logic          q_full;
  logic          pop;

  // Sample width register, 16-bit after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pns_pkg::MODE_16;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign busy = q_full;

  pns_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .mode    (mode_r),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  pns_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  pns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[src/pns_checker.sv]
// Port-level checks for the peak normalizer, bound to the top level.
// Depends on pns_pkg and peak_normalize_samples.
`timescale 1ns / 1ps

module pns_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  out_valid,
  input  pns_pkg::out_item_t    out_data
);

  // The queue is empty right after reset, so commands are taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy high right after reset");

  // No stale result leaves the pipeline after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // An out-of-range read returns a zero sample.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.sample_out == 16'sd0)
    else $error("index error with nonzero sample");

  // A transfer while busy would be lost; busy only rises after a transfer.
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

endmodule

bind peak_normalize_samples pns_checker u_pns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[verif/peak_normalize_samples_tb.sv]
// Self-checking testbench for the peak normalizer: random and directed load/read traffic,
// an in-bench prediction of every read result, and field-by-field checking of the output.
// Depends on pns_pkg and the peak_normalize_samples top level.
`timescale 1ns / 1ps

module peak_normalize_samples_tb;

  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_GOAL     = 1000;
  localparam int FILL_EXTRA    = 3;
  localparam longint GAIN_NUM_8  = 128 * 127;
  localparam longint GAIN_NUM_16 = 32768 * 32767;

  // What the sender does next: issue an item, write the sample width, or wait for quiet.
  typedef enum logic [1:0] {ACT_ITEM, ACT_MODE, ACT_DRAIN} act_kind_t;

  typedef struct packed {
    act_kind_t          kind;
    pns_pkg::in_item_t  item;
    logic               mode_val;
    logic [3:0]         gap;
  } stim_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pns_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  pns_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  // Stimulus waiting to be sent and normalized samples waiting to come back.
  stim_entry_t        pending_ops[$];
  pns_pkg::out_item_t expected_samples[$];
  int                 mismatch_count = 0;

  // Shadow copy of the normalizer state.
  logic [15:0] shadow_store [pns_pkg::STORE_DEPTH];
  int          shadow_count = 0;
  longint      shadow_peak = 0;
  logic [29:0] shadow_gain = '0;
  logic        shadow_closed = 1'b0;
  logic        shadow_mode = pns_pkg::MODE_16;

  // Sender bookkeeping.
  int          quiet_cycles = 0;
  int          gap_waited = 0;

  // Generator bookkeeping: the set as the stimulus will leave it.
  int          gen_count = 0;
  logic        gen_closed = 1'b0;
  logic        no_idle = 1'b0;
  int          item_total = 0;

  peak_normalize_samples u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Interpret a raw word as a signed sample of the given width.
  function automatic longint to_sample(input logic [15:0] raw, input logic mode);
    if (mode == pns_pkg::MODE_8) begin
      return longint'($signed(raw[7:0]));
    end
    return longint'($signed(raw));
  endfunction

  // Apply one accepted transfer to the shadow state; reads queue their expected result.
  function automatic void normalize_step(input pns_pkg::in_item_t it);
    longint             s;
    longint             r;
    longint             divisor;
    longint             num;
    pns_pkg::out_item_t res;
    if (it.cmd == pns_pkg::CMD_LOAD) begin
      if (shadow_closed) begin
        shadow_count  = 0;
        shadow_peak   = 0;
        shadow_gain   = '0;
        shadow_closed = 1'b0;
      end
      if (shadow_count < pns_pkg::STORE_DEPTH) begin
        s = to_sample(it.sample_in, shadow_mode);
        shadow_store[shadow_count] = it.sample_in;
        shadow_count++;
        if (s > shadow_peak) shadow_peak = s;
      end
      if (it.last_in) begin
        divisor = (shadow_peak > 0) ? shadow_peak : 1;
        num = (shadow_mode == pns_pkg::MODE_8) ? GAIN_NUM_8 : GAIN_NUM_16;
        shadow_gain = 30'(num / divisor);
        shadow_closed = 1'b1;
      end
    end else begin
      res = '0;
      if (int'(it.read_index) >= shadow_count) begin
        res.index_error = 1'b1;
      end else begin
        s = to_sample(shadow_store[it.read_index], shadow_mode);
        r = s;
        if (shadow_closed && shadow_peak > 0) begin
          r = (s * longint'(shadow_gain)) >>> ((shadow_mode == pns_pkg::MODE_8) ? 7 : 15);
        end
        res.sample_out = 16'(to_sample(r[15:0], shadow_mode));
      end
      expected_samples.push_back(res);
    end
  endfunction

  // Stimulus builders.
  function automatic logic [3:0] draw_gap();
    return no_idle ? 4'd0 : 4'($urandom_range(0, 8));
  endfunction

  task automatic push_load(input logic [15:0] sample, input logic last);
    stim_entry_t e;
    e = '0;
    e.kind = ACT_ITEM;
    e.item.cmd = pns_pkg::CMD_LOAD;
    e.item.sample_in = sample;
    e.item.last_in = last;
    e.item.read_index = pns_pkg::ADDR_W'($urandom);
    e.gap = draw_gap();
    pending_ops.push_back(e);
    item_total++;
    if (gen_closed) begin
      gen_count = 0;
      gen_closed = 1'b0;
    end
    if (gen_count < pns_pkg::STORE_DEPTH) gen_count++;
    if (last) gen_closed = 1'b1;
  endtask

  task automatic push_read(input int idx, input logic last);
    stim_entry_t e;
    e = '0;
    e.kind = ACT_ITEM;
    e.item.cmd = pns_pkg::CMD_READ;
    e.item.sample_in = 16'($urandom);
    e.item.last_in = last;
    e.item.read_index = pns_pkg::ADDR_W'(idx);
    e.gap = draw_gap();
    pending_ops.push_back(e);
    item_total++;
  endtask

  task automatic push_drain();
    stim_entry_t e;
    e = '0;
    e.kind = ACT_DRAIN;
    pending_ops.push_back(e);
  endtask

  // A width change is only made once the block has gone quiet.
  task automatic push_mode(input logic val);
    stim_entry_t e;
    push_drain();
    e = '0;
    e.kind = ACT_MODE;
    e.mode_val = val;
    pending_ops.push_back(e);
  endtask

  function automatic logic [15:0] draw_sample(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255) - 128);
      2: return 16'(0 - $urandom_range(0, 32768));
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  // Mostly valid positions, some at the boundary and some anywhere.
  function automatic int draw_index();
    int pick;
    pick = $urandom_range(0, 19);
    if (gen_count > 0 && pick < 16) return $urandom_range(0, gen_count - 1);
    if (pick < 18) return gen_count;
    return $urandom_range(0, pns_pkg::STORE_DEPTH - 1);
  endfunction

  // Sender: one transfer per accepted item, gaps drawn per item, width writes when quiet.
  always @(posedge clk) begin : drive_proc
    logic        took;
    logic        nxt_start;
    logic        nxt_cfg_we;
    stim_entry_t head;
    if (!rst_n) begin
      start   <= 1'b0;
      cfg_we  <= 1'b0;
      in_data <= '0;
    end else begin
      took = start && !busy;
      if (took) normalize_step(in_data);
      if (cfg_we) shadow_mode = cfg_wdata;
      if (!start && !cfg_we && expected_samples.size() == 0) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      nxt_start  = start && !took;
      nxt_cfg_we = 1'b0;
      if (!nxt_start && pending_ops.size() != 0) begin
        head = pending_ops[0];
        case (head.kind)
          ACT_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(pending_ops.pop_front());
          end
          ACT_MODE: begin
            nxt_cfg_we = 1'b1;
            cfg_wdata  <= head.mode_val;
            void'(pending_ops.pop_front());
          end
          default: begin
            if (gap_waited < int'(head.gap)) begin
              gap_waited++;
            end else begin
              nxt_start  = 1'b1;
              in_data    <= head.item;
              gap_waited = 0;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
      start  <= nxt_start;
      cfg_we <= nxt_cfg_we;
    end
  end

  // Receiver: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin : check_proc
    pns_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: sample_out=%0d index_error=%0b",
               out_data.sample_out, out_data.index_error);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_data.sample_out);
          mismatch_count++;
        end
        if (out_data.index_error !== want.index_error) begin
          $error("index_error: expected %0b, got %0b", want.index_error, out_data.index_error);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus generation and end of run.
  initial begin : stim_proc
    int   set_len;
    int   style;
    int   n_reads;
    int   fill_items;
    logic filled;
    logic open_set;
    fill_items = 0;
    filled = 1'b0;

    // Directed part, 16-bit width first.
    push_mode(pns_pkg::MODE_16);
    push_read(0, 1'b0);                // nothing loaded yet
    push_load(16'sh7FFF, 1'b0);
    push_load(16'sh8000, 1'b0);
    push_load(16'sh0000, 1'b0);
    push_read(1, 1'b0);                // set still open, unscaled
    push_read(3, 1'b0);                // one past the loaded count
    push_load(16'sh0001, 1'b1);        // closes the set at full-scale peak
    push_read(0, 1'b0);
    push_read(1, 1'b0);
    push_read(3, 1'b0);
    push_read(pns_pkg::STORE_DEPTH - 1, 1'b1);  // last mark on a read is ignored
    push_load(16'shFFFB, 1'b0);        // new set with no positive sample
    push_load(16'sh0000, 1'b1);
    push_read(0, 1'b0);
    push_load(16'sh8000, 1'b0);        // tiny peak, product wraps
    push_load(16'sh0003, 1'b1);
    push_read(0, 1'b0);
    push_read(1, 1'b0);
    push_mode(pns_pkg::MODE_8);
    push_load(16'h7F80, 1'b0);         // negative as an 8-bit sample
    push_load(16'h0140, 1'b1);
    push_read(0, 1'b0);
    push_read(1, 1'b0);
    push_load(16'h00FF, 1'b1);         // single non-positive sample
    push_read(0, 1'b0);

    // Random sets: mostly well formed, some left open or interrupted by reads.
    while (item_total < ITEM_GOAL + fill_items) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) push_mode(1'($urandom_range(0, 1)));
      if (!filled && item_total >= ITEM_GOAL / 2) begin
        // One pass that runs the store full and past it.
        filled = 1'b1;
        no_idle = 1'b1;
        fill_items = pns_pkg::STORE_DEPTH + FILL_EXTRA;
        for (int k = 0; k < fill_items; k++) begin
          push_load(16'($urandom), k == fill_items - 1);
        end
        push_read(pns_pkg::STORE_DEPTH - 1, 1'b0);
        push_read(0, 1'b0);
        for (int k = 0; k < 4; k++) begin
          push_read($urandom_range(0, pns_pkg::STORE_DEPTH - 1), 1'b0);
        end
      end
      set_len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 200);
      style    = $urandom_range(0, 3);
      open_set = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < set_len; k++) begin
        if ($urandom_range(0, 19) == 0) push_read(draw_index(), 1'($urandom));
        if ($urandom_range(0, 59) == 0) push_mode(1'($urandom_range(0, 1)));
        push_load(draw_sample(style), (k == set_len - 1) && !open_set);
      end
      n_reads = $urandom_range(1, 12);
      for (int k = 0; k < n_reads; k++) push_read(draw_index(), 1'($urandom));
    end
    push_mode(pns_pkg::MODE_8);
    push_load(16'h007F, 1'b1);
    push_read(0, 1'b0);
    push_drain();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The final drain entry leaves only once every result is in and the block is quiet.
    while (pending_ops.size() != 0) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
